// ===== rtl/core/fat_chain_engine_top_assert.svh =====
// Assertion macros for the allocation table engine.
`ifndef FAT_CHAIN_ENGINE_TOP_ASSERT_SVH
`define FAT_CHAIN_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FCE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fat chain engine assertion failed");
`define FCE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fat chain engine assertion failed");
`else
`define FCE_ASSERT(lbl, clk, rst_n, prop)
`define FCE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/fce_pkg.sv =====
package fce_pkg;

  localparam int NUM_BLOCKS_DEF  = 4096;
  localparam int BLOCK_BYTES_DEF = 512;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_APPEND = 2'd1,
    OP_FREE   = 2'd2,
    OP_TAIL   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_SIZE = 2'd2,
    ST_LOOP = 2'd3
  } status_t;

endpackage

// ===== rtl/core/fat_chain_engine_top.sv =====
// File allocation table engine. One table entry per block holds a busy bit,
// an end-of-chain bit and a next-block link, kept in one synchronous memory.
// Input channel in_*: one command per transaction (allocate, append, free
// chain, find tail). Output channel out_*: exactly one result transaction per
// command, in order. Only one command is in flight; in_tready is high while
// the engine is idle, also while a finished result still waits on out_*.
// The memory is read one entry per cycle. Allocate scans entries upward
// from the lowest block that may be free; append walks the links to the
// chain's tail and then scans the same way; free chain and find tail walk
// the links of the chain. Walks and scans share the single memory read port.
// After reset a clearing pass writes every entry, one per cycle; no command
// is accepted during it.
// When the receiver stalls, the result is held in the output register and
// the next command may still be accepted; its result waits until the
// output register is free.
module fat_chain_engine_top #(
  parameter int NUM_BLOCKS  = fce_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = fce_pkg::BLOCK_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // opcode[1:0], start_block[13:2], file_size[29:14], zero[31:30]
  input  logic [fce_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // block_out[11:0], chain_links[24:12], tail_offset[34:25], status[36:35], zero[39:37]
  output logic [fce_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import fce_pkg::*;

  `include "fat_chain_engine_top_assert.svh"

  localparam int AW = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LW = AW + 1;
  localparam int HW = AW + 1;
  localparam int PW = LW + $clog2(BLOCK_BYTES + 1);
  localparam int DW = ((PW > 16) ? PW : 16) + 1;

  typedef struct packed {
    logic          busy;
    logic          eoc;
    logic [AW-1:0] next;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_WALK, S_SCAN, S_FREE, S_LINK, S_OFFS, S_DONE
  } state_t;

  entry_t mem [NUM_BLOCKS];
  entry_t rd_data_r;

  state_t        state_r, state_nxt;
  opcode_t       op_r, op_nxt;
  logic [15:0]   fsize_r, fsize_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [HW-1:0] hint_r, hint_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic          tail_busy_r, tail_busy_nxt;
  logic [11:0]   res_blk_r, res_blk_nxt;
  logic [12:0]   res_links_r, res_links_nxt;
  logic [9:0]    res_offs_r, res_offs_nxt;
  status_t       res_st_r, res_st_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic          we;
  logic [AW-1:0] wa;
  entry_t        wd;

  opcode_t       in_op;
  logic [11:0]   in_start;
  logic [15:0]   in_fsize;
  logic          start_ok;
  logic          scan_busy;
  logic [PW-1:0] prod;
  logic [DW-1:0] diff;

  assign in_op    = opcode_t'(in_tdata[1:0]);
  assign in_start = in_tdata[13:2];
  assign in_fsize = in_tdata[29:14];
  assign start_ok = 32'(in_start) < NUM_BLOCKS;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign scan_busy = rd_data_r.busy || (op_r == OP_APPEND && cur_r == tail_r);
  assign prod = PW'(cnt_r) * PW'(BLOCK_BYTES);
  assign diff = DW'(fsize_r) - DW'(prod);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= (we && wa == cur_nxt) ? wd : mem[cur_nxt];
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    fsize_nxt     = fsize_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    hint_nxt      = hint_r;
    tail_nxt      = tail_r;
    tail_busy_nxt = tail_busy_r;
    res_blk_nxt   = res_blk_r;
    res_links_nxt = res_links_r;
    res_offs_nxt  = res_offs_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    wa            = cur_r;
    wd            = '0;

    unique case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        wd.busy = (cur_r == '0);
        wd.eoc  = 1'b1;
        if (32'(cur_r) == NUM_BLOCKS - 1) begin
          state_nxt = S_IDLE;
          hint_nxt  = HW'(1);
          cur_nxt   = '0;
        end else begin
          cur_nxt = cur_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt        = in_op;
          fsize_nxt     = in_fsize;
          cnt_nxt       = '0;
          res_blk_nxt   = '0;
          res_links_nxt = '0;
          res_offs_nxt  = '0;
          res_st_nxt    = ST_OK;
          if (in_op == OP_ALLOC) begin
            if (32'(hint_r) >= NUM_BLOCKS) begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              cur_nxt   = AW'(hint_r);
              state_nxt = S_SCAN;
            end
          end else if (!start_ok) begin
            res_st_nxt = ST_LOOP;
            state_nxt  = S_DONE;
          end else begin
            cur_nxt   = AW'(in_start);
            state_nxt = (in_op == OP_FREE) ? S_FREE : S_WALK;
          end
        end
      end
      S_WALK: begin
        if (rd_data_r.eoc) begin
          tail_nxt      = cur_r;
          tail_busy_nxt = rd_data_r.busy;
          res_blk_nxt   = 12'(cur_r);
          res_links_nxt = 13'(cnt_r);
          if (op_r == OP_TAIL) begin
            state_nxt = S_OFFS;
          end else if (32'(hint_r) >= NUM_BLOCKS) begin
            res_blk_nxt   = '0;
            res_links_nxt = '0;
            res_st_nxt    = ST_FULL;
            state_nxt     = S_DONE;
          end else begin
            cur_nxt   = AW'(hint_r);
            state_nxt = S_SCAN;
          end
        end else if (32'(cnt_r) >= NUM_BLOCKS - 1 || 32'(rd_data_r.next) >= NUM_BLOCKS) begin
          res_st_nxt = ST_LOOP;
          state_nxt  = S_DONE;
        end else begin
          cur_nxt = rd_data_r.next;
          cnt_nxt = cnt_r + LW'(1);
        end
      end
      S_SCAN: begin
        if (!scan_busy) begin
          we          = 1'b1;
          wd.busy     = 1'b1;
          wd.eoc      = 1'b1;
          hint_nxt    = HW'(cur_r) + HW'(1);
          res_blk_nxt = 12'(cur_r);
          if (op_r == OP_APPEND) begin
            cur_nxt   = tail_r;
            tail_nxt  = cur_r;
            state_nxt = S_LINK;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (32'(cur_r) == NUM_BLOCKS - 1) begin
          hint_nxt = (op_r == OP_APPEND && !tail_busy_r && tail_r != '0) ?
                     HW'(tail_r) : HW'(NUM_BLOCKS);
          res_blk_nxt   = '0;
          res_links_nxt = '0;
          res_st_nxt    = ST_FULL;
          state_nxt     = S_DONE;
        end else begin
          cur_nxt  = cur_r + AW'(1);
          hint_nxt = HW'(cur_r) + HW'(1);
        end
      end
      S_LINK: begin
        we        = 1'b1;
        wd.busy   = 1'b1;
        wd.eoc    = 1'b0;
        wd.next   = tail_r;
        state_nxt = S_DONE;
      end
      S_FREE: begin
        we     = 1'b1;
        wd.eoc = 1'b1;
        if (rd_data_r.busy) begin
          cnt_nxt = cnt_r + LW'(1);
        end
        if (cur_r != '0 && HW'(cur_r) < hint_r) begin
          hint_nxt = HW'(cur_r);
        end
        if (rd_data_r.eoc || 32'(rd_data_r.next) >= NUM_BLOCKS) begin
          res_links_nxt = 13'(cnt_nxt);
          state_nxt     = S_DONE;
        end else begin
          cur_nxt = rd_data_r.next;
        end
      end
      S_OFFS: begin
        if (diff[DW-1] || diff > DW'(BLOCK_BYTES)) begin
          res_st_nxt = ST_SIZE;
        end else begin
          res_offs_nxt = 10'(diff);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({res_st_r, res_offs_r, res_links_r, res_blk_r});
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cur_r       <= '0;
      hint_r      <= HW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    fsize_r     <= fsize_nxt;
    cnt_r       <= cnt_nxt;
    tail_r      <= tail_nxt;
    tail_busy_r <= tail_busy_nxt;
    res_blk_r   <= res_blk_nxt;
    res_links_r <= res_links_nxt;
    res_offs_r  <= res_offs_nxt;
    res_st_r    <= res_st_nxt;
    out_data_r  <= out_data_nxt;
  end

  `FCE_ASSERT(a_accept_leaves_idle, clk, rst_n, (in_tvalid && in_tready) |=> (state_r != S_IDLE))
  `FCE_ASSERT(a_hint_nonzero, clk, rst_n, (state_r != S_CLEAR) |-> (hint_r != '0))
  `FCE_ASSERT(a_loop_zero_fields, clk, rst_n, (out_tvalid && out_tdata[36:35] == ST_LOOP) |-> (out_tdata[24:0] == '0))

endmodule
